@@ sv/dueq_pkg.sv @@
// ----------------------------------------------------------------------------
// dueq_pkg: shared types and codes for the upper envelope max query block
// Transaction payloads, table entry layout, request and status codes, and
// the control bundle of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package dueq_pkg;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DOMINATED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // accumulator width: holds the difference of two 49x33-bit products
  localparam int ACC_W = 84;
  localparam int MUL_W = 33;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [31:0]  slope;
    logic signed [47:0]  intercept;
    logic signed [31:0]  query_x;
  } req_t;

  typedef struct packed {
    logic signed [63:0]  max_value;
    logic [1:0]          status;
    logic [6:0]          line_count;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0]  slope;
    logic signed [47:0]  icpt;
  } line_t;

  // one issue slot of the multiply-accumulate unit
  typedef struct packed {
    logic issue;  // product enters the pipe
    logic ld;     // product replaces the accumulator
    logic neg;    // product is subtracted
    logic sh;     // product is weighted by 2**32
  } mac_ctl_t;

endpackage

@@ sv/dueq_table.sv @@
// ----------------------------------------------------------------------------
// dueq_table: line table storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module dueq_table
  import dueq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  line_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output line_t         rd_data
);

  line_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/dueq_mac.sv @@
// ----------------------------------------------------------------------------
// dueq_mac: shared multiply-accumulate unit
// One 33x33 signed multiplier, registered, followed by a registered
// accumulate stage that loads, adds or subtracts the optionally shifted product.
// ----------------------------------------------------------------------------
module dueq_mac
  import dueq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [2*MUL_W-1:0] prod;
  mac_ctl_t                  ctl1;
  logic signed [ACC_W-1:0]   term;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl;
    end
    prod <= a * b;
  end

  // product alignment
  always_comb begin
    if (ctl1.sh) begin
      term = ACC_W'({prod, 32'b0});
    end else begin
      term = ACC_W'(prod);
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctl1.issue) begin
      if (ctl1.ld) begin
        acc <= ctl1.neg ? -term : term;
      end else if (ctl1.neg) begin
        acc <= acc - term;
      end else begin
        acc <= acc + term;
      end
    end
  end

endmodule

@@ sv/dynamic_upper_envelope_max_query.sv @@
// Steps: insert finds its place, shifts the entries above it, runs the neighbor
//   tests with a check step each, and moves entries on a prune; query scans all
//   lines; clear and unused codes go straight to the result register.
// Throughput: one transaction at a time, set by the single table read port and the
//   shared multiply-accumulate unit. Reset clears the line count and the result valid.
// ----------------------------------------------------------------------------
// dynamic_upper_envelope_max_query: upper envelope of lines with max query
// Keeps lines sorted by slope in a table, prunes lines off the envelope with
// exact product compares, and answers max queries by a scan over the table.
// ----------------------------------------------------------------------------
module dynamic_upper_envelope_max_query
  import dueq_pkg::*;
#(
  parameter int MAX_LINES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW  = $clog2(MAX_LINES);
  localparam int CW  = $clog2(MAX_LINES + 1);
  localparam int CW1 = CW + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH_RD  = 4'd1;
  localparam logic [3:0] S_SRCH_CK  = 4'd2;
  localparam logic [3:0] S_SHU_RD   = 4'd3;
  localparam logic [3:0] S_SHU_WR   = 4'd4;
  localparam logic [3:0] S_MID_CK   = 4'd5;
  localparam logic [3:0] S_RIGHT_CK = 4'd6;
  localparam logic [3:0] S_LEFT_CK  = 4'd7;
  localparam logic [3:0] S_TRI      = 4'd8;
  localparam logic [3:0] S_SHD_RD   = 4'd9;
  localparam logic [3:0] S_SHD_WR   = 4'd10;
  localparam logic [3:0] S_QRY      = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;

  // which neighbor test is running
  localparam logic [1:0] PH_MID   = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_LEFT  = 2'd2;

  logic [3:0]             state;
  logic [3:0]             tc;
  logic [1:0]             phase;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          k;
  logic [AW-1:0]          tb;
  req_t                   rq;
  line_t                  lp, lc, ln;
  logic signed [48:0]     dli, dri;
  logic signed [32:0]     dls, drs;
  logic signed [63:0]     maxv;
  logic [1:0]             st;

  logic                   we;
  logic [AW-1:0]          wr_addr;
  line_t                  wr_data;
  logic [AW-1:0]          rd_addr;
  line_t                  rd_data;
  line_t                  new_line;
  mac_ctl_t               mctl;
  logic signed [MUL_W-1:0] ma, mb;
  logic signed [ACC_W-1:0] acc;

  logic [CW1-1:0]         pos_p1, pos_p2, k_p1, cnt_x;
  logic                   full;
  logic signed [63:0]     qv;

  assign new_line = '{slope: rq.slope, icpt: rq.intercept};
  assign pos_p1   = CW1'(pos) + CW1'(1);
  assign pos_p2   = CW1'(pos) + CW1'(2);
  assign k_p1     = CW1'(k) + CW1'(1);
  assign cnt_x    = CW1'(cnt);
  assign full     = (cnt == CW'(MAX_LINES));
  assign qv       = acc[63:0] + {{16{lc.icpt[47]}}, lc.icpt};

  assign req_stall = (state != S_IDLE);

  dueq_table #(.DEPTH(MAX_LINES), .AW(AW)) u_table (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dueq_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mctl),
    .a   (ma),
    .b   (mb),
    .acc (acc)
  );

  // table port and multiplier operand selection
  always_comb begin
    rd_addr = pos[AW-1:0];
    we      = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = new_line;
    mctl    = '0;
    ma      = '0;
    mb      = drs;
    case (state)
      S_SRCH_CK: begin
        if (rd_data.slope == rq.slope && rd_data.icpt < rq.intercept) begin
          we = 1'b1;
        end
      end
      S_SHU_RD: begin
        rd_addr = AW'(k - CW'(1));
        if (k <= pos) begin
          we = 1'b1;
        end
      end
      S_SHU_WR: begin
        we      = 1'b1;
        wr_addr = k[AW-1:0];
        wr_data = rd_data;
      end
      S_SHD_RD: begin
        rd_addr = k_p1[AW-1:0];
      end
      S_SHD_WR: begin
        we      = 1'b1;
        wr_addr = k[AW-1:0];
        wr_data = rd_data;
      end
      S_TRI: begin
        // fetch the three lines, then r minus l over four partial products
        if (tc == 4'd0) begin
          rd_addr = tb;
        end else if (tc == 4'd1) begin
          rd_addr = tb + AW'(1);
        end else begin
          rd_addr = tb + AW'(2);
        end
        if (tc == 4'd5) begin
          mctl = '{issue: 1'b1, ld: 1'b1, neg: 1'b0, sh: 1'b0};
          ma   = {1'b0, dri[31:0]};
          mb   = drs;
        end else if (tc == 4'd6) begin
          mctl = '{issue: 1'b1, ld: 1'b0, neg: 1'b0, sh: 1'b1};
          ma   = {{16{dri[48]}}, dri[48:32]};
          mb   = drs;
        end else if (tc == 4'd7) begin
          mctl = '{issue: 1'b1, ld: 1'b0, neg: 1'b1, sh: 1'b0};
          ma   = {1'b0, dli[31:0]};
          mb   = dls;
        end else if (tc == 4'd8) begin
          mctl = '{issue: 1'b1, ld: 1'b0, neg: 1'b1, sh: 1'b1};
          ma   = {{16{dli[48]}}, dli[48:32]};
          mb   = dls;
        end
      end
      S_QRY: begin
        rd_addr = k[AW-1:0];
        if (tc == 4'd1) begin
          mctl = '{issue: 1'b1, ld: 1'b1, neg: 1'b0, sh: 1'b0};
          ma   = {rd_data.slope[31], rd_data.slope};
          mb   = {rq.query_x[31], rq.query_x};
        end
      end
      default: begin
        rd_addr = pos[AW-1:0];
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            rq   <= req;
            maxv <= '0;
            st   <= ST_OK;
            pos  <= '0;
            k    <= '0;
            tc   <= '0;
            case (req.req_type)
              REQ_INSERT: state <= S_SRCH_RD;
              REQ_QUERY: begin
                if (cnt == '0) begin
                  st    <= ST_EMPTY;
                  state <= S_FIN;
                end else begin
                  state <= S_QRY;
                end
              end
              REQ_CLEAR: begin
                cnt   <= '0;
                state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_SRCH_RD: begin
          if (pos < cnt) begin
            state <= S_SRCH_CK;
          end else if (full) begin
            st    <= ST_FULL;
            state <= S_FIN;
          end else begin
            k     <= cnt;
            state <= S_SHU_RD;
          end
        end
        S_SRCH_CK: begin
          if (rd_data.slope < rq.slope) begin
            pos   <= pos + CW'(1);
            state <= S_SRCH_RD;
          end else if (rd_data.slope == rq.slope) begin
            if (rq.intercept <= rd_data.icpt) begin
              st    <= ST_DOMINATED;
              state <= S_FIN;
            end else begin
              state <= S_MID_CK;
            end
          end else if (full) begin
            st    <= ST_FULL;
            state <= S_FIN;
          end else begin
            k     <= cnt;
            state <= S_SHU_RD;
          end
        end
        S_SHU_RD: begin
          if (k > pos) begin
            state <= S_SHU_WR;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_MID_CK;
          end
        end
        S_SHU_WR: begin
          k     <= k - CW'(1);
          state <= S_SHU_RD;
        end
        S_MID_CK: begin
          tc <= '0;
          if (pos != '0 && pos_p1 < cnt_x) begin
            tb    <= AW'(pos - CW'(1));
            phase <= PH_MID;
            state <= S_TRI;
          end else begin
            state <= S_RIGHT_CK;
          end
        end
        S_RIGHT_CK: begin
          tc <= '0;
          if (pos_p2 < cnt_x) begin
            tb    <= pos[AW-1:0];
            phase <= PH_RIGHT;
            state <= S_TRI;
          end else begin
            state <= S_LEFT_CK;
          end
        end
        S_LEFT_CK: begin
          tc <= '0;
          if (pos >= CW'(2)) begin
            tb    <= AW'(pos - CW'(2));
            phase <= PH_LEFT;
            state <= S_TRI;
          end else begin
            st    <= ST_OK;
            state <= S_FIN;
          end
        end
        S_TRI: begin
          tc <= tc + 4'd1;
          if (tc == 4'd1) begin
            lp <= rd_data;
          end
          if (tc == 4'd2) begin
            lc <= rd_data;
          end
          if (tc == 4'd3) begin
            ln <= rd_data;
          end
          // slope and intercept differences of the triple
          if (tc == 4'd4) begin
            dli <= {lc.icpt[47], lc.icpt} - {ln.icpt[47], ln.icpt};
            dls <= {lc.slope[31], lc.slope} - {lp.slope[31], lp.slope};
            dri <= {lp.icpt[47], lp.icpt} - {lc.icpt[47], lc.icpt};
            drs <= {ln.slope[31], ln.slope} - {lc.slope[31], lc.slope};
          end
          // middle line redundant when r minus l is not negative
          if (tc == 4'd10) begin
            if (!acc[ACC_W-1]) begin
              k     <= CW'(tb) + CW'(1);
              state <= S_SHD_RD;
            end else begin
              case (phase)
                PH_MID:   state <= S_RIGHT_CK;
                PH_RIGHT: state <= S_LEFT_CK;
                default: begin
                  st    <= ST_OK;
                  state <= S_FIN;
                end
              endcase
            end
          end
        end
        S_SHD_RD: begin
          if (k_p1 < cnt_x) begin
            state <= S_SHD_WR;
          end else begin
            cnt <= cnt - CW'(1);
            case (phase)
              PH_MID: begin
                st    <= ST_DOMINATED;
                state <= S_FIN;
              end
              PH_RIGHT: state <= S_RIGHT_CK;
              default: begin
                pos   <= pos - CW'(1);
                state <= S_LEFT_CK;
              end
            endcase
          end
        end
        S_SHD_WR: begin
          k     <= k + CW'(1);
          state <= S_SHD_RD;
        end
        S_QRY: begin
          if (tc == 4'd1) begin
            lc <= rd_data;
          end
          // running maximum over the scan
          if (tc == 4'd3) begin
            if (k == '0 || qv > maxv) begin
              maxv <= qv;
            end
            tc <= '0;
            if (k_p1 == cnt_x) begin
              state <= S_FIN;
            end else begin
              k <= k + CW'(1);
            end
          end else begin
            tc <= tc + 4'd1;
          end
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            rsp.max_value  <= maxv;
            rsp.status     <= st;
            rsp.line_count <= 7'(cnt);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/dueq_checker.sv @@
// ----------------------------------------------------------------------------
// dueq_props: port-level checks for the upper envelope max query block
// Watches both transaction channels and the result payload over time.
// ----------------------------------------------------------------------------
module dueq_props
  import dueq_pkg::*;
#(
  parameter int MAX_LINES = 64
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  // empty query reports an empty table
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.line_count == 7'd0 && rsp.max_value == 64'sd0)
    else $error("empty status with lines or value");

  // full status only with a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.line_count == 7'(MAX_LINES)
      && rsp.max_value == 64'sd0)
    else $error("full status with table not full");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind dynamic_upper_envelope_max_query dueq_props #(.MAX_LINES(MAX_LINES)) u_dueq_props (.*);

@@ sim/dueq_checker.sv @@
// ----------------------------------------------------------------------------
// dueq_checker: scoreboard for the upper envelope max query block
// Watches both channels, predicts each response with its own copy of the
// line table, and compares responses field by field in order.
// ----------------------------------------------------------------------------
module dueq_checker
  import dueq_pkg::*;
#(
  parameter int MAX_LINES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending,
  output int   n_rsp,
  output int   n_full,
  output int   n_dom
);

  logic signed [31:0] env_slope [MAX_LINES];
  logic signed [47:0] env_icpt  [MAX_LINES];
  int                 env_n;
  rsp_t               rsp_queue [$];

  initial begin
    errors = 0;
    n_rsp = 0;
    n_full = 0;
    n_dom = 0;
    env_n = 0;
  end

  assign pending = rsp_queue.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic void drop_line(input int i);
    for (int k = i; k + 1 < env_n; k++) begin
      env_slope[k] = env_slope[k + 1];
      env_icpt[k]  = env_icpt[k + 1];
    end
    env_n--;
  endfunction

  // middle line is off the envelope of its two neighbors, exact products
  function automatic logic is_hidden(input int p, input int c, input int n);
    logic signed [127:0] lhs, rhs;
    lhs = ($signed(128'(env_icpt[c])) - env_icpt[n]) * ($signed(128'(env_slope[c])) - env_slope[p]);
    rhs = ($signed(128'(env_icpt[p])) - env_icpt[c]) * ($signed(128'(env_slope[n])) - env_slope[c]);
    return lhs <= rhs;
  endfunction

  function automatic logic [1:0] add_line(input logic signed [31:0] a,
                                          input logic signed [47:0] b);
    int pos;
    pos = 0;
    while (pos < env_n && env_slope[pos] < a) pos++;
    if (pos < env_n && env_slope[pos] == a) begin
      if (b <= env_icpt[pos]) return ST_DOMINATED;
      drop_line(pos);
    end else if (env_n >= MAX_LINES) begin
      return ST_FULL;
    end
    for (int k = env_n; k > pos; k--) begin
      env_slope[k] = env_slope[k - 1];
      env_icpt[k]  = env_icpt[k - 1];
    end
    env_slope[pos] = a;
    env_icpt[pos]  = b;
    env_n++;
    if (pos > 0 && pos + 1 < env_n && is_hidden(pos - 1, pos, pos + 1)) begin
      drop_line(pos);
      return ST_DOMINATED;
    end
    while (pos + 2 < env_n && is_hidden(pos, pos + 1, pos + 2)) drop_line(pos + 1);
    while (pos >= 2 && is_hidden(pos - 2, pos - 1, pos)) begin
      drop_line(pos - 1);
      pos--;
    end
    return ST_OK;
  endfunction

  function automatic rsp_t predict_rsp(input req_t r);
    rsp_t               o;
    logic signed [63:0] v;
    o = '0;
    case (r.req_type)
      REQ_INSERT: o.status = add_line(r.slope, r.intercept);
      REQ_QUERY: begin
        if (env_n == 0) o.status = ST_EMPTY;
        else begin
          for (int i = 0; i < env_n; i++) begin
            v = 64'(env_slope[i]) * 64'(r.query_x) + 64'(env_icpt[i]);
            if (i == 0 || v > o.max_value) o.max_value = v;
          end
        end
      end
      REQ_CLEAR: env_n = 0;
      default: ;
    endcase
    o.line_count = 7'(env_n);
    return o;
  endfunction

  // predict on each request transaction, compare on each response transaction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) rsp_queue.push_back(predict_rsp(req));
      if (rsp_valid && !rsp_stall) begin
        n_rsp++;
        if (rsp_queue.size() == 0) begin
          report("unexpected response", rsp.max_value, 64'(0));
        end else begin
          want = rsp_queue.pop_front();
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_DOMINATED) n_dom++;
          if (rsp.max_value !== want.max_value) report("max_value", rsp.max_value, want.max_value);
          if (rsp.status !== want.status)
            report("status", 64'(rsp.status), 64'(want.status));
          if (rsp.line_count !== want.line_count)
            report("line_count", 64'(rsp.line_count), 64'(want.line_count));
        end
      end
    end
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for the upper envelope max query block
// Drives directed and random inserts, queries, clears and unused codes with random
// idling on both channels, and gives the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import dueq_pkg::*;

  localparam int  N_LINES   = 64;
  localparam int  N_RANDOM  = 1020;
  localparam longint LIMIT  = 5000000;

  logic   clk = 0;
  logic   rst = 1;
  logic   req_valid = 0;
  logic   req_stall;
  req_t   req = '0;
  logic   rsp_valid;
  logic   rsp_stall = 1;
  rsp_t   rsp;
  int     errors, pending, n_rsp, n_full, n_dom;
  int     send_idle_pct = 34;
  int     recv_idle_pct = 60;
  int     hold_off = 0;
  logic   hold_req = 0;
  logic   hold_seen = 0;
  int     n_sent = 0;
  longint cycle = 0;

  always #4 clk = ~clk;

  dynamic_upper_envelope_max_query #(.MAX_LINES(N_LINES)) dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  dueq_checker #(.MAX_LINES(N_LINES)) chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp), .errors(errors),
    .pending(pending), .n_rsp(n_rsp), .n_full(n_full), .n_dom(n_dom)
  );

  // cycle limit
  always @(posedge clk) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall, with one long hold-off when requested
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1;
      hold_off  <= 400;
      rsp_stall <= 1;
    end else if (hold_off > 0) begin
      rsp_stall <= 1;
      hold_off  <= hold_off - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one request transaction and wait for its acceptance
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic req_t mk_req(input logic [1:0] t, input logic [31:0] a,
                                  input logic [47:0] b, input logic [31:0] x);
    req_t r;
    r.req_type  = t;
    r.slope     = a;
    r.intercept = b;
    r.query_x   = x;
    return r;
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(40)) - 20);
      2: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                  : 32'h7fff_fffc + $urandom_range(3);
      default: return 32'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic logic [47:0] rnd48();
    case ($urandom_range(3))
      0: return 48'({$urandom(), $urandom()});
      1: return 48'($signed($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? 48'h8000_0000_0000 + $urandom_range(3)
                                  : 48'h7fff_ffff_fffc + $urandom_range(3);
      default: return 48'($signed($urandom_range(100000)) - 50000);
    endcase
  endfunction

  // parabola-like lines: all on the envelope, so the table fills
  task automatic fill_table(input int n);
    for (int i = 0; i < n; i++)
      send_req(mk_req(REQ_INSERT, 32'(i - 40), 48'(-(i - 40) * (i - 40)), 0));
  endtask

  task automatic random_req();
    logic [1:0] t;
    int         p;
    p = $urandom_range(99);
    t = p < 55 ? REQ_INSERT : p < 93 ? REQ_QUERY : p < 98 ? REQ_CLEAR : REQ_UNUSED;
    send_req(mk_req(t, rnd32(), rnd48(), rnd32()));
  endtask

  task automatic drain();
    req_valid <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty query, extremes, same slope, dominated, unused code, clear
    send_req(mk_req(REQ_QUERY, 0, 0, 5));
    send_req(mk_req(REQ_INSERT, 32'h8000_0000, 48'h8000_0000_0000, 0));
    send_req(mk_req(REQ_INSERT, 32'h7fff_ffff, 48'h7fff_ffff_ffff, 0));
    send_req(mk_req(REQ_QUERY, 0, 0, 32'h8000_0000));
    send_req(mk_req(REQ_QUERY, 0, 0, 32'h7fff_ffff));
    send_req(mk_req(REQ_INSERT, 0, 48'h8000_0000_0000, 0));
    send_req(mk_req(REQ_INSERT, 0, 48'h7fff_ffff_ffff, 0));
    send_req(mk_req(REQ_INSERT, 0, 48'h7fff_ffff_ffff, 0));
    send_req(mk_req(REQ_INSERT, 0, 48'h7fff_ffff_fff0, 0));
    send_req(mk_req(REQ_UNUSED, 32'hffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff));
    send_req(mk_req(REQ_QUERY, 32'hffff_ffff, 48'hffff_ffff_ffff, 0));
    send_req(mk_req(REQ_CLEAR, 0, 0, 0));
    send_req(mk_req(REQ_INSERT, -1, 0, 0));
    send_req(mk_req(REQ_INSERT, 1, 0, 0));
    send_req(mk_req(REQ_INSERT, 0, -5, 0));
    send_req(mk_req(REQ_INSERT, 0, 10, 0));
    send_req(mk_req(REQ_QUERY, 0, 0, 3));
    send_req(mk_req(REQ_CLEAR, 0, 0, 0));

    // full table, then a new slope that must be refused
    fill_table(N_LINES);
    send_req(mk_req(REQ_INSERT, 1000, 0, 0));
    send_req(mk_req(REQ_QUERY, 0, 0, 7));

    // receiver holds off while the sender keeps offering
    drain();
    hold_req = 1;
    repeat (8) random_req();

    // random phases with changing idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 34 : ph == 1 ? 60 : 0;
      recv_idle_pct = ph == 0 ? 60 : ph == 1 ? 34 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        if ($urandom_range(199) == 0) fill_table(N_LINES + 2);
        random_req();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    $display("sent %0d requests, checked %0d responses (%0d full, %0d dominated)",
             n_sent, n_rsp, n_full, n_dom);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dueq_pkg.sv
sv/dueq_table.sv
sv/dueq_mac.sv
sv/dynamic_upper_envelope_max_query.sv
sv/dueq_checker.sv
sim/dueq_checker.sv
sim/tb.sv
